>>> design/swerve_pkg.sv
// ----------------------------------------------------------------------------
// swerve_pkg: shared types and constants
// Data widths, fixed-point constants and the arctangent table used by the
// three-module swerve kinematics pipeline.
// ----------------------------------------------------------------------------
package swerve_pkg;

    // Working width of all velocity datapaths (Q16 rpm, signed)
    localparam int DW = 40;

    localparam int TAB_LEN = 24;

    localparam logic [29:0] K_Q30          = 30'd652032874;
    localparam logic [29:0] HALF_SQRT3_Q30 = 30'd929887698;
    localparam logic [14:0] SPEED_MAX      = 15'd32767;

    typedef logic signed [DW-1:0] vel_t;

    typedef enum logic [1:0] {
        REG_DEADBAND    = 2'd0,
        REG_LINEAR_GAIN = 2'd1,
        REG_TURN_GAIN   = 2'd2,
        REG_HEADING     = 2'd3
    } reg_idx_t;

    // Arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/swerve_three_module_kinematics.sv
// ----------------------------------------------------------------------------
// swerve_three_module_kinematics: three-module swerve inverse kinematics
// Fully pipelined rotation and vectoring CORDIC path, one command per cycle while the output is not held.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one drive command per beat:
//   lin_x, lin_y, turn_rate in signed Q1.15. Output channel
//   (out_valid/out_ready) returns one beat per command: a steering angle
//   (binary angle, 65536 per turn) and a wheel speed (rpm) per module.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the pipeline is empty, and the block
//   itself does not enforce this.
// Throughput: one beat per cycle while the output is not held; every stage is
//   a register set, and the rotation and the three vectoring CORDICs each
//   spend one stage per iteration.
// Reset: all valid bits clear, so the pipeline is empty; configuration
//   registers return to deadband 1638, linear gain 500, turn gain 2187,
//   heading 0.
// Stall: when the output beat is held, the whole pipeline freezes; nothing
//   is dropped or repeated, and in_ready falls only while the last stage
//   holds a beat the receiver has not taken.
// ----------------------------------------------------------------------------
module swerve_three_module_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] lin_x,
    input  logic signed [15:0] lin_y,
    input  logic signed [15:0] turn_rate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] angle_one,
    output logic signed [15:0] angle_two,
    output logic signed [15:0] angle_three,
    output logic [14:0]        speed_one,
    output logic [14:0]        speed_two,
    output logic [14:0]        speed_three
);

    localparam int N  = CORDIC_STAGES;
    localparam int DW = swerve_pkg::DW;
    // Stage map: 0 deadband, 1 gains, 2 prerotate, 3..N+2 rotate,
    // N+3 gain removal, N+4 module sums, N+5 vector init,
    // N+6..2N+5 vectoring, 2N+6 output
    localparam int L  = 7 + 2 * N;

    // ---------------- configuration ----------------
    logic [14:0]        deadband_reg;
    logic [11:0]        linear_gain_reg;
    logic [12:0]        turn_gain_reg;
    logic signed [15:0] heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= 15'd1638;
            linear_gain_reg <= 12'd500;
            turn_gain_reg   <= 13'd2187;
            heading_reg     <= 16'sd0;
        end
        else if (cfg_we)
        begin
            case (swerve_pkg::reg_idx_t'(cfg_index))
                swerve_pkg::REG_DEADBAND:    deadband_reg    <= cfg_data[14:0];
                swerve_pkg::REG_LINEAR_GAIN: linear_gain_reg <= cfg_data[11:0];
                swerve_pkg::REG_TURN_GAIN:   turn_gain_reg   <= cfg_data[12:0];
                swerve_pkg::REG_HEADING:     heading_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Advance every stage together unless the last beat is held.
    logic         adv;
    logic [L-1:0] vld_reg;

    assign adv       = !vld_reg[L-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], in_valid};
    end

    // ---------------- stage 0: negate turn, deadband ----------------
    function automatic logic signed [16:0] dband(input logic signed [16:0] v,
                                                 input logic [14:0] db);
        logic [16:0] mag;
        mag = v[16] ? 17'(-v) : 17'(v);
        return (mag < {2'b00, db}) ? 17'sd0 : v;
    endfunction

    logic signed [16:0] jx_reg, jy_reg, jw_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            jx_reg <= dband(17'(lin_x), deadband_reg);
            jy_reg <= dband(17'(lin_y), deadband_reg);
            jw_reg <= dband(-17'(turn_rate), deadband_reg);
        end
    end

    // ---------------- stage 1: gains ----------------
    logic signed [DW-1:0] vx_reg, vy_reg, w_reg, wh_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg <= DW'(jx_reg * $signed({1'b0, linear_gain_reg})) <<< 1;
            vy_reg <= DW'(jy_reg * $signed({1'b0, linear_gain_reg})) <<< 1;
            w_reg  <= DW'(jw_reg * $signed({1'b0, turn_gain_reg})) <<< 1;
            wh_reg <= DW'(jw_reg * $signed({1'b0, turn_gain_reg}));
        end
    end

    // Multiply by a Q30 constant, rounding half away from zero
    function automatic logic signed [DW-1:0] mul_q30(input logic signed [DW-1:0] v,
                                                     input logic [29:0] k);
        logic [DW-1:0] a;
        logic [63:0]   p;
        logic [DW-1:0] m;
        a = v[DW-1] ? DW'(-v) : DW'(v);
        p = {32'd0, a[31:0]} * {34'd0, k} + 64'd536870912;
        m = DW'(p >> 30);
        return v[DW-1] ? DW'(-m) : DW'(m);
    endfunction

    // ---------------- stage 2: w*sqrt(3)/2, heading prerotate ----------------
    logic signed [DW-1:0] rx_reg [0:N];
    logic signed [DW-1:0] ry_reg [0:N];
    logic signed [33:0]   rz_reg [0:N];
    logic signed [DW-1:0] cw_reg  [0:N];
    logic signed [DW-1:0] cwc_reg [0:N];
    logic signed [DW-1:0] cwh_reg [0:N];

    logic signed [33:0] z_init;
    logic               flip;

    always_comb
    begin
        z_init = 34'(heading_reg) <<< 16;
        flip   = 1'b0;
        if (z_init > 34'sd1073741824)
        begin
            z_init = z_init - 34'sd2147483648;
            flip   = 1'b1;
        end
        else if (z_init < -34'sd1073741824)
        begin
            z_init = z_init + 34'sd2147483648;
            flip   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg[0]  <= flip ? -vx_reg : vx_reg;
            ry_reg[0]  <= flip ? -vy_reg : vy_reg;
            rz_reg[0]  <= z_init;
            cw_reg[0]  <= w_reg;
            cwh_reg[0] <= wh_reg;
            cwc_reg[0] <= mul_q30(w_reg, swerve_pkg::HALF_SQRT3_Q30);
        end
    end

    // ---------------- rotation CORDIC, one iteration per stage ----------------
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic signed [33:0] ATAN =
            34'($unsigned(swerve_pkg::atan_tab(i)));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rz_reg[i] >= 34'sd0)
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] - ATAN;
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] + ATAN;
                end
                cw_reg[i+1]  <= cw_reg[i];
                cwc_reg[i+1] <= cwc_reg[i];
                cwh_reg[i+1] <= cwh_reg[i];
            end
        end
    end

    // ---------------- remove rotation gain ----------------
    logic signed [DW-1:0] gx_reg, gy_reg, gw_reg, gwc_reg, gwh_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg  <= mul_q30(rx_reg[N], swerve_pkg::K_Q30);
            gy_reg  <= mul_q30(ry_reg[N], swerve_pkg::K_Q30);
            gw_reg  <= cw_reg[N];
            gwc_reg <= cwc_reg[N];
            gwh_reg <= cwh_reg[N];
        end
    end

    // ---------------- module vectors ----------------
    logic signed [DW-1:0] mx_reg [0:2];
    logic signed [DW-1:0] my_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg[0] <= gx_reg + gwc_reg;
            my_reg[0] <= gy_reg + gwh_reg;
            mx_reg[1] <= gx_reg - gw_reg;
            my_reg[1] <= gy_reg;
            mx_reg[2] <= gx_reg;
            my_reg[2] <= gy_reg - gw_reg;
        end
    end

    // ---------------- vectoring CORDICs ----------------
    logic [14:0]        spd [0:2];
    logic signed [15:0] ang [0:2];

    for (genvar m = 0; m < 3; m++)
    begin : g_mod
        logic signed [DW-1:0] x_reg [0:N];
        logic signed [DW-1:0] y_reg [0:N];
        logic [31:0]          z_reg [0:N];
        logic                 zero_reg [0:N];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                zero_reg[0] <= (mx_reg[m] == '0) && (my_reg[m] == '0);
                if (mx_reg[m] < 0)
                begin
                    x_reg[0] <= -mx_reg[m];
                    y_reg[0] <= -my_reg[m];
                    z_reg[0] <= 32'h8000_0000;
                end
                else
                begin
                    x_reg[0] <= mx_reg[m];
                    y_reg[0] <= my_reg[m];
                    z_reg[0] <= 32'd0;
                end
            end
        end

        for (genvar j = 0; j < N; j++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (y_reg[j] >= 0)
                    begin
                        x_reg[j+1] <= x_reg[j] + (y_reg[j] >>> j);
                        y_reg[j+1] <= y_reg[j] - (x_reg[j] >>> j);
                        z_reg[j+1] <= z_reg[j] + swerve_pkg::atan_tab(j);
                    end
                    else
                    begin
                        x_reg[j+1] <= x_reg[j] - (y_reg[j] >>> j);
                        y_reg[j+1] <= y_reg[j] + (x_reg[j] >>> j);
                        z_reg[j+1] <= z_reg[j] - swerve_pkg::atan_tab(j);
                    end
                    zero_reg[j+1] <= zero_reg[j];
                end
            end
        end

        // Output stage: round angle, scale magnitude, saturate
        logic [31:0]        zr;
        logic [31:0]        mag;
        logic [63:0]        prod;
        logic [17:0]        rpm;
        logic signed [15:0] ang_reg;
        logic [14:0]        spd_reg;

        always_comb
        begin
            zr   = z_reg[N] + 32'h0000_8000;
            mag  = x_reg[N][DW-1] ? 32'd0 : x_reg[N][31:0];
            prod = {32'd0, mag} * {34'd0, swerve_pkg::K_Q30} + (64'd1 << 45);
            rpm  = prod[63:46];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (zero_reg[N])
                begin
                    ang_reg <= 16'sd0;
                    spd_reg <= 15'd0;
                end
                else
                begin
                    ang_reg <= $signed(zr[31:16]);
                    spd_reg <= (rpm > 18'(swerve_pkg::SPEED_MAX)) ?
                               swerve_pkg::SPEED_MAX : rpm[14:0];
                end
            end
        end

        assign ang[m] = ang_reg;
        assign spd[m] = spd_reg;
    end

    assign angle_one   = ang[0];
    assign angle_two   = ang[1];
    assign angle_three = ang[2];
    assign speed_one   = spd[0];
    assign speed_two   = spd[1];
    assign speed_three = spd[2];

endmodule
